// ===== rtl/core/skl_pkg.sv =====
package skl_pkg;

  // Field widths of the request and result ports
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // Default list depth
  localparam int DEPTH_DEF = 16;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic rd_en;      // read the entry at rd_addr into the read register
    logic wr_en;      // write an entry at wr_addr
    logic wr_shift;   // write data: 1 = read register, 0 = request entry
    logic load_req;   // capture the request key and tag, clear removed tag
    logic load_rtag;  // capture the tag of the read register as removed tag
  } skl_cmd_t;

endpackage

// ===== rtl/core/skl_datapath.sv =====
module skl_datapath
  import skl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  skl_cmd_t                                   cmd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [KEY_W-1:0]                           in_key,
  input  logic [TAG_W-1:0]                           in_tag,
  output logic                                       key_le,
  output logic [TAG_W-1:0]                           removed_tag
);

  localparam int ENTRY_W = KEY_W + TAG_W;

  logic [ENTRY_W-1:0] entry_mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic [KEY_W-1:0]   key_r;
  logic [TAG_W-1:0]   tag_r;
  logic [TAG_W-1:0]   rtag_r;
  logic [TAG_W-1:0]   rtag_nxt;
  logic [ENTRY_W-1:0] wdata;

  // Select write data: shifted neighbor or the new entry
  assign wdata = cmd.wr_shift ? rdata_r : {key_r, tag_r};

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      entry_mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= entry_mem[rd_addr];
    end
  end

  // Hold the request entry
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key_r <= in_key;
      tag_r <= in_tag;
    end
  end

  // Track the removed tag, zero unless a remove succeeds
  always_comb begin
    rtag_nxt = rtag_r;
    if (cmd.load_req) begin
      rtag_nxt = '0;
    end else if (cmd.load_rtag) begin
      rtag_nxt = rdata_r[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtag_r <= '0;
    end else begin
      rtag_r <= rtag_nxt;
    end
  end

  // Compare the new key against the entry just read
  assign key_le      = key_r <= rdata_r[ENTRY_W-1:TAG_W];
  assign removed_tag = rtag_r;

endmodule

// ===== rtl/core/skl_ctrl.sv =====
module skl_ctrl
  import skl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic                                       in_op,
  input  logic [POS_W-1:0]                           in_position,
  input  logic                                       key_le,
  output logic                                       busy,
  output skl_cmd_t                                   cmd,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic                                       out_valid,
  output logic [STATUS_W-1:0]                        out_status,
  output logic [SLOT_W-1:0]                          out_slot,
  output logic [COUNT_W-1:0]                         out_count
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = CW + 1;
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam int SXW   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int CXW   = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;
  localparam logic [2:0] ST_INS_PUT = 3'd2;
  localparam logic [2:0] ST_REM_TAG = 3'd3;
  localparam logic [2:0] ST_REM_SH  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                valid_r, valid_nxt;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    cnt_w;
  logic [EW-1:0]       idx_e;
  logic [EW-1:0]       cnt_e;
  logic [SXW-1:0]      slot_x;
  logic [CXW-1:0]      count_x;

  assign pos_w = CMP_W'(in_position);
  assign cnt_w = CMP_W'(count_r);
  assign idx_e = EW'(idx_r);
  assign cnt_e = EW'(count_r);

  // Sequence one request: a shift pass over the list where needed, then one result strobe
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    valid_nxt  = 1'b0;
    cmd        = '0;
    rd_addr    = '0;
    wr_addr    = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          if (in_op == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              // refuse: list full
              status_nxt = STAT_FULL;
              slot_nxt   = '0;
              valid_nxt  = 1'b1;
            end else if (count_r == '0) begin
              idx_nxt   = '0;
              state_nxt = ST_INS_PUT;
            end else begin
              idx_nxt    = AW'(count_r);
              cmd.rd_en  = 1'b1;
              rd_addr    = AW'(count_r - CW'(1));
              state_nxt  = ST_INS_CMP;
            end
          end else begin
            if (pos_w >= cnt_w) begin
              // refuse: position beyond the stored entries
              status_nxt = STAT_BAD_POS;
              slot_nxt   = '0;
              valid_nxt  = 1'b1;
            end else begin
              idx_nxt   = pos_w[AW-1:0];
              slot_nxt  = pos_w[AW-1:0];
              cmd.rd_en = 1'b1;
              rd_addr   = pos_w[AW-1:0];
              state_nxt = ST_REM_TAG;
            end
          end
        end
      end
      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (key_le) begin
          // move the entry with the larger or equal key up one place
          cmd.wr_shift = 1'b1;
          idx_nxt      = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = ST_INS_PUT;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx_r - AW'(2);
          end
        end else begin
          status_nxt = STAT_DONE;
          slot_nxt   = idx_r;
          count_nxt  = count_r + CW'(1);
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        status_nxt = STAT_DONE;
        slot_nxt   = idx_r;
        count_nxt  = count_r + CW'(1);
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_REM_TAG: begin
        cmd.load_rtag = 1'b1;
        if (idx_e + EW'(1) < cnt_e) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_r + AW'(1);
          state_nxt = ST_REM_SH;
        end else begin
          status_nxt = STAT_DONE;
          count_nxt  = count_r - CW'(1);
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_REM_SH: begin
        // move the next entry down one place
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        idx_nxt      = idx_r + AW'(1);
        if (idx_e + EW'(2) < cnt_e) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_r + AW'(2);
        end else begin
          status_nxt = STAT_DONE;
          count_nxt  = count_r - CW'(1);
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
  end

  // Drive the result ports
  assign slot_x     = SXW'(slot_r);
  assign count_x    = CXW'(count_r);
  assign busy       = state_r != ST_IDLE;
  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_slot   = slot_x[SLOT_W-1:0];
  assign out_count  = count_x[COUNT_W-1:0];

endmodule

// ===== rtl/core/sorted_key_list_core.sv =====
// Sorted key list: insert in ascending key order, remove by position.
// A shift pass moves stored entries one per cycle through the entry memory, which has
// one write port and one registered read port.
// Refused requests (list full, bad position) answer on the next cycle.
// Throughput: one request per result; start is taken whenever busy is low.
// Reset (rst_n low, synchronous) empties the list; results cannot be stalled.
module sorted_key_list_core
  import skl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [TAG_W-1:0]    in_tag,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [TAG_W-1:0]    out_removed_tag,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  skl_cmd_t      cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          key_le;

  skl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_op       (in_op),
    .in_position (in_position),
    .key_le      (key_le),
    .busy        (busy),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_count   (out_count)
  );

  skl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .in_key      (in_key),
    .in_tag      (in_tag),
    .key_le      (key_le),
    .removed_tag (out_removed_tag)
  );

  // An accepted request either starts a pass or answers on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request produced neither work nor a result");

  // No result while a pass is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Refused requests never report a removed tag or a slot
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DONE |-> out_removed_tag == '0 && out_slot == '0)
    else $error("refused request carries slot or tag");

  // Only defined status codes leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_DONE || out_status == STAT_FULL ||
                  out_status == STAT_BAD_POS)
    else $error("undefined status code");

endmodule

// ===== tb/sv/tb_sorted_key_list_core.sv =====
module tb_sorted_key_list_core;
  import skl_pkg::*;

  // One result of the list: status, slot used, removed tag and new count
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    removed_tag;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  // Shadow copy of the sorted list plus the queue of results it predicts
  class sorted_list_tracker;
    logic [KEY_W-1:0] key_mem [DEPTH_DEF];
    logic [TAG_W-1:0] tag_mem [DEPTH_DEF];
    int unsigned      n_entries;
    list_result_t     pending_results [$];
    int unsigned      n_errors;
    int unsigned      n_inserts;
    int unsigned      n_removes;
    int unsigned      n_full;
    int unsigned      n_bad_pos;
    int unsigned      n_checked;
    int unsigned      peak_fill;

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                               logic [POS_W-1:0] pos);
      list_result_t r;
      int unsigned  i;
      r = '0;
      if (op == OP_INSERT) begin
        if (n_entries >= DEPTH_DEF) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          // Walk down from the top, moving up every entry with a key >= the new one
          i = n_entries;
          while (i > 0 && key <= key_mem[i-1]) begin
            key_mem[i] = key_mem[i-1];
            tag_mem[i] = tag_mem[i-1];
            i--;
          end
          key_mem[i] = key;
          tag_mem[i] = tag;
          n_entries++;
          r.status = STAT_DONE;
          r.slot   = SLOT_W'(i);
          n_inserts++;
        end
      end else begin
        if (pos >= n_entries) begin
          r.status = STAT_BAD_POS;
          n_bad_pos++;
        end else begin
          // Take the entry out and close the hole
          r.status      = STAT_DONE;
          r.slot        = pos;
          r.removed_tag = tag_mem[pos];
          n_entries--;
          for (i = pos; i < n_entries; i++) begin
            key_mem[i] = key_mem[i+1];
            tag_mem[i] = tag_mem[i+1];
          end
          n_removes++;
        end
      end
      r.count = COUNT_W'(n_entries);
      if (n_entries > peak_fill) peak_fill = n_entries;
      pending_results.push_back(r);
    endfunction

    // Compare one result strobe against the oldest prediction
    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic [TAG_W-1:0] rtag, logic [COUNT_W-1:0] count);
      list_result_t exp_r;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors < 40)
          $display("%0t: unexpected result status=%0d slot=%0d tag=%h count=%0d",
                   $time, status, slot, rtag, count);
        return;
      end
      exp_r = pending_results.pop_front();
      n_checked++;
      if (status !== exp_r.status) report_field("status", exp_r.status, status);
      if (slot !== exp_r.slot) report_field("slot", exp_r.slot, slot);
      if (rtag !== exp_r.removed_tag) report_field("removed_tag", exp_r.removed_tag, rtag);
      if (count !== exp_r.count) report_field("count", exp_r.count, count);
    endfunction

    function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      n_errors++;
      if (n_errors < 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_op;
  logic [KEY_W-1:0]    in_key;
  logic [TAG_W-1:0]    in_tag;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [TAG_W-1:0]    out_removed_tag;
  logic [COUNT_W-1:0]  out_count;

  sorted_list_tracker tracker;
  bit                 gaps_on;
  int unsigned        n_sent;

  sorted_key_list_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_tag          (in_tag),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_removed_tag (out_removed_tag),
    .out_count       (out_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_status, out_slot, out_removed_tag, out_count);
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Keys: full range, small integer masses, copies of stored keys, extremes, low 16-bit keys
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 65) return {16'($urandom_range(0, 7)), 16'h0000};
    if (r < 80 && tracker.n_entries > 0)
      return tracker.key_mem[$urandom_range(0, tracker.n_entries - 1)];
    if (r < 90) return ($urandom_range(0, 1) != 0) ? {KEY_W{1'b1}} : '0;
    return $urandom & 32'h0000_ffff;
  endfunction

  // Hold start low to leave a gap between requests
  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Present one request and hold it until the block takes it
  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                              logic [POS_W-1:0] pos);
    @(negedge clk);
    start       <= 1'b1;
    in_op       <= op;
    in_key      <= key;
    in_tag      <= tag;
    in_position <= pos;
    do @(posedge clk); while (busy);
    tracker.note_request(op, key, tag, pos);
    n_sent++;
    idle_for(gaps_on ? gap_cycles() : 0);
  endtask

  // Stop sending until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned insert_pct;
    logic        op;
    logic [POS_W-1:0] pos;

    tracker     = new;
    gaps_on     = 1'b1;
    n_sent      = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_INSERT;
    in_key      = '0;
    in_tag      = '0;
    in_position = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list removes, extremes, equal keys, full list
    send_request(OP_REMOVE, '0, '0, 4'd0);
    send_request(OP_REMOVE, {KEY_W{1'b1}}, {TAG_W{1'b1}}, 4'd15);
    send_request(OP_INSERT, 32'h0001_0000, 16'h0001, 4'd0);
    send_request(OP_INSERT, 32'hffff_ffff, 16'hffff, 4'd15);
    send_request(OP_INSERT, 32'h0000_0000, 16'h0000, 4'd7);
    send_request(OP_INSERT, 32'h0001_0000, 16'h0002, 4'd0);
    send_request(OP_INSERT, 32'h8000_0000, 16'ha5a5, 4'd9);
    send_request(OP_REMOVE, '0, '0, 4'd5);
    send_request(OP_REMOVE, '0, '0, 4'd4);
    send_request(OP_REMOVE, '0, '0, 4'd0);
    for (int k = 0; k < 13; k++)
      send_request(OP_INSERT, 32'h1111_1111 * (k % 5), 16'(16'h0100 + k), POS_W'(k));
    send_request(OP_INSERT, 32'h2222_2222, 16'h5a5a, 4'd3);
    send_request(OP_REMOVE, '0, '0, 4'd15);
    wait_drained();

    // Random phases that lean toward filling, churning or draining the list
    phase = 0;
    while (n_sent < 870) begin
      phase_len = $urandom_range(15, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if (op == OP_REMOVE && tracker.n_entries > 0 && $urandom_range(0, 99) < 85)
          pos = POS_W'($urandom_range(0, tracker.n_entries - 1));
        else
          pos = POS_W'($urandom_range(0, 15));
        send_request(op, pick_key(), TAG_W'($urandom), pos);
      end
      phase++;
      if (phase % 3 == 0) wait_drained();
    end

    gaps_on = 1'b1;
    wait_drained();
    repeat (24) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.n_errors++;
      $display("%0t: %0d results never arrived", $time, tracker.pending());
    end

    $display("covered %0d requests: %0d placed, %0d removed, %0d refused as full, %0d bad",
             n_sent, tracker.n_inserts, tracker.n_removes, tracker.n_full, tracker.n_bad_pos);
    $display("results checked %0d, list fill reached %0d of %0d entries",
             tracker.n_checked, tracker.peak_fill, DEPTH_DEF);
    if (tracker.n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Give up on a hung block
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/skl_pkg.sv
rtl/core/skl_datapath.sv
rtl/core/skl_ctrl.sv
rtl/core/sorted_key_list_core.sv
tb/sv/tb_sorted_key_list_core.sv
